// File: rtl/xbm_pkg.sv
package xbm_pkg;

  // Sizes of the block.
  localparam int MAX_SIDE_DEFAULT = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int SIDE_CFG_W = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int VALUE_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_IS_16 = 2'd2;

  // Characters the lexer looks for.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  typedef enum logic [2:0] {
    PH_SCAN    = 3'd0,
    PH_SLASH   = 3'd1,
    PH_COMMENT = 3'd2,
    PH_STAR    = 3'd3,
    PH_ZERO    = 3'd4,
    PH_DIGITS  = 3'd5
  } lex_phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } number_base_t;

  typedef struct packed {
    lex_phase_t           phase;
    number_base_t         base;
    logic [VALUE_W-1:0]   value;
  } lex_state_t;

  typedef struct packed {
    logic                 ok;
    logic [3:0]           value;
  } digit_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0]          pixel_bits;
    logic [4:0]           pixel_count;
    logic                 row_end;
    logic                 image_end;
  } out_item_t;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] image_width;
    logic [SIDE_CFG_W-1:0] image_height;
    logic                  word_is_16;
  } cfg_t;

endpackage

// File: rtl/xbm_front.sv
module xbm_front import xbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [VALUE_W-1:0] push_value
);

  localparam lex_state_t LEX_CLEAR = '{phase: PH_SCAN, base: BASE_DEC, value: '0};

  lex_state_t st;
  lex_state_t st_next;
  logic       emit;
  logic [7:0] c;
  digit_t     dg;

  // Classify a byte seen between numbers.
  function automatic lex_state_t scan(lex_state_t s, logic [7:0] ch);
    lex_state_t r;
    r = s;
    r.phase = PH_SCAN;
    if (ch == CH_SLASH) begin
      r.phase = PH_SLASH;
    end else if (ch == CH_0) begin
      r.phase = PH_ZERO;
      r.value = '0;
    end else if (ch >= CH_1 && ch <= CH_9) begin
      r.phase = PH_DIGITS;
      r.base = BASE_DEC;
      r.value = VALUE_W'(ch - CH_0);
    end
    return r;
  endfunction

  // Value of a digit character in the given base.
  function automatic digit_t digit_of(logic [7:0] ch, number_base_t b);
    digit_t d;
    d.ok = 1'b0;
    d.value = '0;
    if (ch >= CH_0 && ch <= CH_9) begin
      d.ok = 1'b1;
      d.value = 4'(ch - CH_0);
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      d.ok = 1'b1;
      d.value = 4'(ch - CH_LA + 8'd10);
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      d.ok = 1'b1;
      d.value = 4'(ch - CH_UA + 8'd10);
    end
    case (b)
      BASE_OCT: if (d.value > 4'd7) d.ok = 1'b0;
      BASE_HEX: ;
      default:  if (d.value > 4'd9) d.ok = 1'b0;
    endcase
    return d;
  endfunction

  // Shift in one digit, wrapping at the value width.
  function automatic logic [VALUE_W-1:0] mac(logic [VALUE_W-1:0] v, number_base_t b,
                                             logic [3:0] d);
    logic [VALUE_W-1:0] r;
    case (b)
      BASE_OCT: r = {v[VALUE_W-4:0], 3'b000} + VALUE_W'(d);
      BASE_HEX: r = {v[VALUE_W-5:0], 4'b0000} + VALUE_W'(d);
      default:  r = {v[VALUE_W-4:0], 3'b000} + {v[VALUE_W-2:0], 1'b0} + VALUE_W'(d);
    endcase
    return r;
  endfunction

  assign c = in_item.data_byte;
  assign in_ready = push_ready;
  assign dg = digit_of(c, (st.phase == PH_ZERO) ? BASE_OCT : st.base);

  // Lexer next state; a byte that closes a number is scanned again at once.
  always_comb begin
    st_next = st;
    emit = 1'b0;
    push_value = st.value;
    if (in_item.end_of_data) begin
      if (st.phase == PH_ZERO || st.phase == PH_DIGITS) begin
        emit = 1'b1;
      end
      if (st.phase == PH_ZERO) begin
        push_value = '0;
      end
      st_next = LEX_CLEAR;
    end else begin
      unique case (st.phase)
        PH_SLASH: begin
          if (c == CH_STAR) st_next.phase = PH_COMMENT;
          else st_next = scan(st, c);
        end
        PH_COMMENT: begin
          if (c == CH_STAR) st_next.phase = PH_STAR;
        end
        PH_STAR: begin
          if (c == CH_SLASH) st_next.phase = PH_SCAN;
          else if (c != CH_STAR) st_next.phase = PH_COMMENT;
        end
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            st_next = '{phase: PH_DIGITS, base: BASE_HEX, value: '0};
          end else if (dg.ok) begin
            st_next = '{phase: PH_DIGITS, base: BASE_OCT, value: VALUE_W'(dg.value)};
          end else begin
            emit = 1'b1;
            push_value = '0;
            st_next = scan(LEX_CLEAR, c);
          end
        end
        PH_DIGITS: begin
          if (dg.ok) begin
            st_next.value = mac(st.value, st.base, dg.value);
          end else begin
            emit = 1'b1;
            st_next = scan(LEX_CLEAR, c);
          end
        end
        default: begin
          st_next = scan(st, c);
        end
      endcase
    end
  end

  assign push_valid = in_valid && in_ready && emit;

  // Lexer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LEX_CLEAR;
    end else if (in_valid && in_ready) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/xbm_queue.sv
module xbm_queue import xbm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  logic [VALUE_W-1:0] push_value,
  output logic               pop_valid,
  input  logic               pop_ready,
  output logic [VALUE_W-1:0] pop_value
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_value = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Storage of queued numbers.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_value;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");
`endif

endmodule

// File: rtl/xbm_back.sv
module xbm_back import xbm_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [VALUE_W-1:0] pop_value,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W = $clog2(MAX_SIDE);
  localparam int CMP_W = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;

  logic [POS_W-1:0]  column;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  column_next;
  logic [POS_W-1:0]  row_next;
  logic [SIDE_W-1:0] w;
  logic [SIDE_W-1:0] h;
  logic [SIDE_W-1:0] col_eff;
  logic [SIDE_W-1:0] row_eff;
  logic [SIDE_W-1:0] left;
  logic [SIDE_W-1:0] col_sum;
  logic [SIDE_W-1:0] row_inc;
  logic [4:0]        bits;
  logic [4:0]        cnt;
  logic [16:0]       mask;
  logic              take;
  out_item_t         item_next;

  // Limit a size register to the range 1 to MAX_SIDE.
  function automatic logic [SIDE_W-1:0] side(logic [SIDE_CFG_W-1:0] v);
    logic [CMP_W-1:0] e;
    e = CMP_W'(v);
    if (e == '0) return SIDE_W'(1);
    if (e > CMP_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return SIDE_W'(e);
  endfunction

  assign w = side(cfg.image_width);
  assign h = side(cfg.image_height);
  assign bits = cfg.word_is_16 ? 5'd16 : 5'd8;

  assign pop_ready = !out_valid || out_ready;
  assign take = pop_valid && pop_ready;

  // Pixel group for the number at the head of the queue.
  always_comb begin
    col_eff = (SIDE_W'(column) >= w) ? '0 : SIDE_W'(column);
    row_eff = (SIDE_W'(row) >= h) ? '0 : SIDE_W'(row);
    left = w - col_eff;
    cnt = (left < SIDE_W'(bits)) ? left[4:0] : bits;
    mask = (17'd1 << cnt) - 17'd1;
    col_sum = col_eff + SIDE_W'(cnt);
    row_inc = row_eff + SIDE_W'(1);
    item_next.pixel_bits = ~pop_value & mask[15:0];
    item_next.pixel_count = cnt;
    item_next.row_end = 1'b0;
    item_next.image_end = 1'b0;
    column_next = POS_W'(col_sum);
    row_next = POS_W'(row_eff);
    if (col_sum >= w) begin
      item_next.row_end = 1'b1;
      column_next = '0;
      if (row_inc >= h) begin
        item_next.image_end = 1'b1;
        row_next = '0;
      end else begin
        row_next = POS_W'(row_inc);
      end
    end
  end

  // Position in the image.
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row <= '0;
    end else if (take) begin
      column <= column_next;
      row <= row_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= item_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.pixel_count >= 5'd1 && out_item.pixel_count <= 5'd16))
    else $error("pixel count out of range");
  a_bits_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.pixel_bits >> out_item.pixel_count) == 16'd0))
    else $error("pixel bits set above pixel count");
  a_image_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.image_end) |-> out_item.row_end)
    else $error("image end without row end");
`endif

endmodule

// File: rtl/xbm_data_text_to_pixels.sv
// Decodes the data section of an X bitmap text file, one byte per request on the
// input channel, into groups of up to 16 pixels on the output channel. The lexer
// takes a byte in every cycle while the queue has room; a closed number is queued
// and turned into one pixel group (inverted bits, LSB is the leftmost pixel) with
// row and image end marks. The rate is up to one byte per cycle and one group per cycle
// while neither the queue nor the output is stalled; a group is held in the queue
// memory and then the output register, and the queue of QUEUE_DEPTH numbers lets
// the lexer keep going while the output is stalled.
// Write image_width, image_height and word_is_16 only while the block is idle.
module xbm_data_text_to_pixels import xbm_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  cfg_t               cfg;
  logic               push_valid;
  logic               push_ready;
  logic [VALUE_W-1:0] push_value;
  logic               pop_valid;
  logic               pop_ready;
  logic [VALUE_W-1:0] pop_value;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= SIDE_CFG_W'(8);
      cfg.image_height <= SIDE_CFG_W'(8);
      cfg.word_is_16 <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width <= cfg_data[SIDE_CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIDE_CFG_W-1:0];
        REG_WORD_IS_16:   cfg.word_is_16 <= cfg_data[0];
        default: ;
      endcase
    end
  end

  xbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value)
  );

  xbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_value  (pop_value)
  );

  xbm_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_value (pop_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
